// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg: shared types for the length-prefixed deframer
// Field widths, the front-to-back command, the region release notice, the
// result record and the back-end sequencer states.
// ----------------------------------------------------------------------------
package lpd_pkg;

   // Fixed field widths of the request and response ports.
   localparam int CLIENT_W = 3;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;

   // Command queue between the front and back ends.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   // Result queue at the response side.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 3;

   // A finished packet (value holds its length) or a rejected length byte.
   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic [BYTE_W-1:0]   value;
      logic                error;
   } cmd_type;

   // The back end has read the last byte of a client's region.
   typedef struct packed {
      logic                valid;
      logic [CLIENT_W-1:0] client;
   } rel_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic [INDEX_W-1:0]  index;
      logic [BYTE_W-1:0]   data;
      logic                last;
      logic                error;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

// ===== rtl/lpd_front.sv =====
// ----------------------------------------------------------------------------
// lpd_front: request intake and classification
// Registers each request, checks the length byte, tracks per-client progress,
// writes packet bytes to the store and queues finished packets or errors.
// ----------------------------------------------------------------------------
module lpd_front #(
   parameter int NUM_CLIENTS      = 8,
   parameter int MAX_PACKET_BYTES = 64,
   parameter int STORE_AW         = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [lpd_pkg::CLIENT_W-1:0]  req_client_id,
   input  logic [lpd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          cmd_push,
   output lpd_pkg::cmd_type              cmd_data,
   input  logic                          cmd_full,
   output logic                          wr_en,
   output logic [STORE_AW-1:0]           wr_addr,
   output logic [lpd_pkg::BYTE_W-1:0]    wr_data,
   input  lpd_pkg::rel_type              rel
);
   import lpd_pkg::*;

   localparam int CLIENTS_USED = (NUM_CLIENTS < (1 << CLIENT_W)) ?
                                 NUM_CLIENTS : (1 << CLIENT_W);
   localparam int CIDX_W = (CLIENTS_USED > 1) ? $clog2(CLIENTS_USED) : 1;
   localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);

   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   logic [CLIENT_W-1:0]  hold_client_ff;
   logic [BYTE_W-1:0]    hold_byte_ff;

   logic [CNT_W-1:0]     cnt_ff  [CLIENTS_USED];
   logic [CNT_W-1:0]     exp_ff  [CLIENTS_USED];
   logic                 busy_ff [CLIENTS_USED];

   logic                 accept;
   logic                 in_range;
   logic [CIDX_W-1:0]    c_idx;
   logic [CNT_W-1:0]     count;
   logic                 first;
   logic                 bad_len;
   logic [CNT_W-1:0]     exp_cur;
   logic                 stale;
   logic [CNT_W-1:0]     cnt_next;
   logic                 done;
   logic                 consume;
   logic                 cnt_we;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W-1:0]     exp_in;
   logic                 busy_set;
   logic [15:0]          addr_wide;
   logic [CIDX_W-1:0]    rel_idx;

   // One request is held at a time; a new one enters once it is consumed.
   assign full   = hold_valid_ff;
   assign accept = push && !full;

   // Per-client view of the held request.
   assign in_range = ({6'd0, hold_client_ff} < 9'(NUM_CLIENTS));
   assign c_idx    = hold_client_ff[CIDX_W-1:0];
   assign count    = cnt_ff[c_idx];
   assign first    = (count == '0);
   assign bad_len  = first && ((hold_byte_ff == '0) ||
                               (hold_byte_ff > BYTE_W'(MAX_PACKET_BYTES)));
   assign exp_cur  = first ? CNT_W'(hold_byte_ff) : exp_ff[c_idx];
   assign stale    = (count >= CNT_W'(MAX_PACKET_BYTES)) || (count >= exp_cur);
   assign cnt_next = count + CNT_W'(1);
   assign done     = (cnt_next == exp_cur);

   // Store address of the next byte in this client's region.
   assign addr_wide = 16'(c_idx) * 16'(MAX_PACKET_BYTES) + 16'(count);
   assign wr_addr   = addr_wide[STORE_AW-1:0];
   assign wr_data   = hold_byte_ff;

   // Classification of the held request.
   always_comb begin
      consume       = 1'b0;
      cnt_we        = 1'b0;
      cnt_in        = '0;
      exp_in        = '0;
      busy_set      = 1'b0;
      wr_en         = 1'b0;
      cmd_push      = 1'b0;
      cmd_data      = '0;
      cmd_data.client = hold_client_ff;
      if (hold_valid_ff) begin
         if (!in_range) begin
            // Unknown client: dropped without effect.
            consume = 1'b1;
         end else if (bad_len) begin
            if (!cmd_full) begin
               cmd_push       = 1'b1;
               cmd_data.value = hold_byte_ff;
               cmd_data.error = 1'b1;
               consume        = 1'b1;
            end
         end else if (busy_ff[c_idx]) begin
            // Region still being read out: wait.
            consume = 1'b0;
         end else if (stale) begin
            // Inconsistent progress: restart the client.
            consume = 1'b1;
            cnt_we  = 1'b1;
            cnt_in  = '0;
            exp_in  = exp_ff[c_idx];
         end else if (!done) begin
            consume = 1'b1;
            wr_en   = 1'b1;
            cnt_we  = 1'b1;
            cnt_in  = cnt_next;
            exp_in  = exp_cur;
         end else if (!cmd_full) begin
            consume        = 1'b1;
            wr_en          = 1'b1;
            cnt_we         = 1'b1;
            cnt_in         = '0;
            exp_in         = '0;
            busy_set       = 1'b1;
            cmd_push       = 1'b1;
            cmd_data.value = BYTE_W'(cnt_next);
         end
      end
   end

   // Holding register valid flag.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (consume) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Held request payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_client_ff <= req_client_id;
         hold_byte_ff   <= req_data_byte;
      end
   end

   assign rel_idx = rel.client[CIDX_W-1:0];

   // Per-client progress and region ownership.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CLIENTS_USED; i++) begin
         if (reset) begin
            cnt_ff[i]  <= '0;
            exp_ff[i]  <= '0;
            busy_ff[i] <= 1'b0;
         end else begin
            if (cnt_we && (c_idx == CIDX_W'(i))) begin
               cnt_ff[i] <= cnt_in;
               exp_ff[i] <= exp_in;
            end
            if (busy_set && (c_idx == CIDX_W'(i))) begin
               busy_ff[i] <= 1'b1;
            end else if (rel.valid && (rel_idx == CIDX_W'(i))) begin
               busy_ff[i] <= 1'b0;
            end
         end
      end
   end

endmodule

// ===== rtl/lpd_cmdq.sv =====
// ----------------------------------------------------------------------------
// lpd_cmdq: command queue between front and back ends
// A short first-in first-out queue of finished-packet and error commands.
// ----------------------------------------------------------------------------
module lpd_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpd_pkg::cmd_type  din,
   output logic              full,
   input  logic              pop,
   output lpd_pkg::cmd_type  dout,
   output logic              empty
);
   import lpd_pkg::*;

   cmd_type               q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0] count_ff;
   logic [CMDQ_CNT_W-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = q_ff[rd_ptr_ff];

   // Occupancy.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_PTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/lpd_back.sv =====
// ----------------------------------------------------------------------------
// lpd_back: packet store and read-out sequencer
// Holds the packet store, reads each finished packet out byte by byte and
// places the results, and one result per error command, in the response queue.
// ----------------------------------------------------------------------------
module lpd_back #(
   parameter int NUM_CLIENTS      = 8,
   parameter int MAX_PACKET_BYTES = 64,
   parameter int STORE_AW         = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  lpd_pkg::cmd_type              cmd_data,
   output logic                          cmd_pop,
   input  logic                          wr_en,
   input  logic [STORE_AW-1:0]           wr_addr,
   input  logic [lpd_pkg::BYTE_W-1:0]    wr_data,
   output lpd_pkg::rel_type              rel,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output lpd_pkg::rsp_type              rsp_data
);
   import lpd_pkg::*;

   localparam int CLIENTS_USED = (NUM_CLIENTS < (1 << CLIENT_W)) ?
                                 NUM_CLIENTS : (1 << CLIENT_W);
   localparam int CIDX_W      = (CLIENTS_USED > 1) ? $clog2(CLIENTS_USED) : 1;
   localparam int STORE_DEPTH = CLIENTS_USED * MAX_PACKET_BYTES;

   logic [BYTE_W-1:0]     store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]     rd_data_ff;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [CLIENT_W-1:0]   cur_client_ff;
   logic [INDEX_W-1:0]    last_idx_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [INDEX_W-1:0]    idx_in;

   logic                  s1_valid_ff;
   rsp_type               s1_meta_ff;

   rsp_type               oq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] oq_wr_ptr_ff;
   logic [OUTQ_PTR_W-1:0] oq_rd_ptr_ff;
   logic [OUTQ_CNT_W-1:0] oq_count_ff;
   logic [OUTQ_CNT_W-1:0] oq_count_in;

   logic                  space;
   logic                  issue;
   rsp_type               issue_meta;
   logic                  rd_en;
   logic                  load_pkt;
   logic                  at_last;
   logic [15:0]           rd_addr_wide;
   logic [STORE_AW-1:0]   rd_addr;
   rsp_type               push_data;
   logic                  oq_pop;

   // Room for one more result, counting the one in flight.
   assign space   = ((oq_count_ff + OUTQ_CNT_W'(s1_valid_ff)) < OUTQ_CNT_W'(OUTQ_DEPTH));
   assign at_last = (idx_ff == last_idx_ff);

   assign rd_addr_wide = 16'(cur_client_ff[CIDX_W-1:0]) * 16'(MAX_PACKET_BYTES) +
                         16'(idx_ff);
   assign rd_addr      = rd_addr_wide[STORE_AW-1:0];

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && space && !cmd_data.error) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (space && at_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      cmd_pop    = 1'b0;
      issue      = 1'b0;
      issue_meta = '0;
      rd_en      = 1'b0;
      load_pkt   = 1'b0;
      rel        = '0;
      rel.client = cur_client_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && space) begin
               cmd_pop = 1'b1;
               if (cmd_data.error) begin
                  issue            = 1'b1;
                  issue_meta.client = cmd_data.client;
                  issue_meta.data  = cmd_data.value;
                  issue_meta.last  = 1'b1;
                  issue_meta.error = 1'b1;
               end else begin
                  load_pkt = 1'b1;
               end
            end
         end
         BK_READ: begin
            if (space) begin
               issue             = 1'b1;
               rd_en             = 1'b1;
               issue_meta.client = cur_client_ff;
               issue_meta.index  = idx_ff;
               issue_meta.last   = at_last;
               rel.valid         = at_last;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // Byte position within the packet being read out.
   always_comb begin
      idx_in = idx_ff;
      if (load_pkt) begin
         idx_in = '0;
      end else if (rd_en) begin
         idx_in = idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (load_pkt) begin
         cur_client_ff <= cmd_data.client;
         last_idx_ff   <= INDEX_W'(cmd_data.value - BYTE_W'(1));
      end
      if (issue) begin
         s1_meta_ff <= issue_meta;
      end
   end

   // Packet store: one write port from the front end, one registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Result assembly: error results carry their own byte.
   always_comb begin
      push_data = s1_meta_ff;
      if (!s1_meta_ff.error) begin
         push_data.data = rd_data_ff;
      end
   end

   // Response queue.
   assign rsp_empty = (oq_count_ff == '0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_ff[oq_rd_ptr_ff];

   always_comb begin
      oq_count_in = oq_count_ff;
      if (s1_valid_ff && !oq_pop) begin
         oq_count_in = oq_count_ff + OUTQ_CNT_W'(1);
      end else if (oq_pop && !s1_valid_ff) begin
         oq_count_in = oq_count_ff - OUTQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         oq_count_ff <= oq_count_in;
         if (s1_valid_ff) begin
            oq_wr_ptr_ff <= oq_wr_ptr_ff + OUTQ_PTR_W'(1);
         end
         if (oq_pop) begin
            oq_rd_ptr_ff <= oq_rd_ptr_ff + OUTQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         oq_ff[oq_wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/per_client_length_prefixed_deframer.sv =====
// ----------------------------------------------------------------------------
// per_client_length_prefixed_deframer: per-client packet reassembly
// Collects length-prefixed packets from interleaved client byte streams and
// emits each finished packet, byte by byte, or one error per bad length.
// ----------------------------------------------------------------------------
//
//   Channel    Handshake        Payload
//   request    push / full      req_client_id, req_data_byte
//   response   pop / empty      rsp_source_client, rsp_byte_index,
//                               rsp_packet_byte, rsp_last, rsp_length_error
//
// In the front end a request is first registered, then classified, and its
// byte is written into the packet store. A finished packet leaves at one
// byte per cycle while the response queue has room, set by the single read
// port of the packet store; its first result passes the command queue, the
// sequencer's load step and the store read register into the response queue.
// Reset is synchronous and clears all control state; the store needs no
// clearing pass. A byte for a client whose previous packet is still being
// read out waits in the front end until then; a bad length byte does not.
//
module per_client_length_prefixed_deframer #(
   parameter int NUM_CLIENTS      = 8,
   parameter int MAX_PACKET_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [lpd_pkg::CLIENT_W-1:0]  req_client_id,
   input  logic [lpd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [lpd_pkg::CLIENT_W-1:0]  rsp_source_client,
   output logic [lpd_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [lpd_pkg::BYTE_W-1:0]    rsp_packet_byte,
   output logic                          rsp_last,
   output logic                          rsp_length_error
);
   import lpd_pkg::*;

   localparam int CLIENTS_USED = (NUM_CLIENTS < (1 << CLIENT_W)) ?
                                 NUM_CLIENTS : (1 << CLIENT_W);
   localparam int STORE_AW = $clog2(CLIENTS_USED * MAX_PACKET_BYTES);

   logic                 cmdq_push;
   cmd_type              cmdq_din;
   logic                 cmdq_full;
   logic                 cmdq_pop;
   cmd_type              cmdq_dout;
   logic                 cmdq_empty;
   logic                 wr_en;
   logic [STORE_AW-1:0]  wr_addr;
   logic [BYTE_W-1:0]    wr_data;
   rel_type              rel;
   rsp_type              rsp_data;

   lpd_front #(
      .NUM_CLIENTS      (NUM_CLIENTS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .STORE_AW         (STORE_AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_client_id (req_client_id),
      .req_data_byte (req_data_byte),
      .cmd_push      (cmdq_push),
      .cmd_data      (cmdq_din),
      .cmd_full      (cmdq_full),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rel           (rel)
   );

   lpd_cmdq u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (cmdq_push),
      .din   (cmdq_din),
      .full  (cmdq_full),
      .pop   (cmdq_pop),
      .dout  (cmdq_dout),
      .empty (cmdq_empty)
   );

   lpd_back #(
      .NUM_CLIENTS      (NUM_CLIENTS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .STORE_AW         (STORE_AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmdq_empty),
      .cmd_data  (cmdq_dout),
      .cmd_pop   (cmdq_pop),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rel       (rel),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

   // Response fields.
   assign rsp_source_client = rsp_data.client;
   assign rsp_byte_index    = rsp_data.index;
   assign rsp_packet_byte   = rsp_data.data;
   assign rsp_last          = rsp_data.last;
   assign rsp_length_error  = rsp_data.error;

   // The front end only queues a command when the queue has room.
   a_cmdq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmdq_push |-> !cmdq_full)
      else $error("command pushed into a full queue");

   // An error result is always a single, final result at position zero.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_length_error) |-> (rsp_last && (rsp_byte_index == '0)))
      else $error("malformed error result");

   // No result is waiting straight after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response queue not empty after reset");

endmodule

// ===== verif/packet_rebuild_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_rebuild_monitor: response prediction and comparison for the deframer
// Watches both queue-style channels of the deframer. Every accepted request
// is run through a local model of the per-client packet reassembly, and the
// results it implies are queued. Every accepted response is compared, field by
// field, with the oldest queued result.
// ----------------------------------------------------------------------------
module packet_rebuild_monitor #(
   parameter int NUM_CLIENTS      = 8,
   parameter int MAX_PACKET_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [lpd_pkg::CLIENT_W-1:0]  req_client_id,
   input  logic [lpd_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          empty,
   input  logic                          pop,
   input  logic [lpd_pkg::CLIENT_W-1:0]  rsp_source_client,
   input  logic [lpd_pkg::INDEX_W-1:0]   rsp_byte_index,
   input  logic [lpd_pkg::BYTE_W-1:0]    rsp_packet_byte,
   input  logic                          rsp_last,
   input  logic                          rsp_length_error,
   output int                            mismatch_count,
   output int                            outstanding
);

   import lpd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Local copy of the reassembly state, one slot per client.
   logic [6:0]        held_count   [NUM_CLIENTS];
   logic [6:0]        frame_length [NUM_CLIENTS];
   logic [BYTE_W-1:0] frame_bytes  [NUM_CLIENTS][MAX_PACKET_BYTES];

   // Results that the accepted requests imply, oldest first.
   rsp_type due_rsp_q[$];

   // Appends one predicted result to the queue.
   task automatic queue_result(input logic [CLIENT_W-1:0] client, input int index,
                               input logic [BYTE_W-1:0] value, input logic is_last,
                               input logic err_flag);
      rsp_type item;
      item.client = client;
      item.index  = INDEX_W'(index);
      item.data   = value;
      item.last   = is_last;
      item.error  = err_flag;
      due_rsp_q.push_back(item);
   endtask

   // Feeds one request byte into the client's packet in progress and queues
   // the results that it causes.
   task automatic absorb_byte(input logic [CLIENT_W-1:0] client,
                              input logic [BYTE_W-1:0] value);
      int count;
      if (int'(client) >= NUM_CLIENTS) return;
      count = held_count[client];

      // A length byte opens a packet; zero or an oversize length is rejected.
      if (count == 0) begin
         if (value == 0 || int'(value) > MAX_PACKET_BYTES) begin
            queue_result(client, 0, value, 1'b1, 1'b1);
            return;
         end
         frame_length[client] = 7'(value);
      end

      // Defensive restart; normal traffic never gets here.
      if (count >= MAX_PACKET_BYTES || count >= int'(frame_length[client])) begin
         held_count[client] = '0;
         return;
      end

      frame_bytes[client][count] = value;
      count++;
      if (count < int'(frame_length[client])) begin
         held_count[client] = 7'(count);
         return;
      end

      // The packet is complete: every byte leaves in order.
      for (int i = 0; i < count; i++) begin
         queue_result(client, i, frame_bytes[client][i], i == count - 1, 1'b0);
      end
      held_count[client]   = '0;
      frame_length[client] = '0;
   endtask

   // Compare accepted responses first, then predict from accepted requests.
   always @(posedge clock) begin : compare
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         due_rsp_q.delete();
         mismatch_count = 0;
         for (int c = 0; c < NUM_CLIENTS; c++) begin
            held_count[c]   = '0;
            frame_length[c] = '0;
         end
      end else begin
         if (pop && !empty) begin
            seen.client = rsp_source_client;
            seen.index  = rsp_byte_index;
            seen.data   = rsp_packet_byte;
            seen.last   = rsp_last;
            seen.error  = rsp_length_error;
            if (due_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: stray response client %0d idx %0d byte %02h last %b err %b",
                           $realtime, seen.client, seen.index, seen.data, seen.last,
                           seen.error);
               end
            end else begin
               want = due_rsp_q.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected client %0d idx %0d byte %02h last %b err %b",
                              $realtime, want.client, want.index, want.data, want.last,
                              want.error);
                     $display("%0t:   actual client %0d idx %0d byte %02h last %b err %b",
                              $realtime, seen.client, seen.index, seen.data, seen.last,
                              seen.error);
                  end
               end
            end
         end
         if (push && !full) begin
            absorb_byte(req_client_id, req_data_byte);
         end
      end
      outstanding = due_rsp_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the length-prefixed deframer
// Sends a short directed set of requests covering bad lengths, one-byte
// packets and interleaved clients, then mostly well-formed random packets on
// random clients, with random gaps on both channels. Checking is done by the
// monitor instantiated beside the block.
// ----------------------------------------------------------------------------
module testbench;

   import lpd_pkg::*;

   localparam int NUM_CLIENTS      = 8;
   localparam int MAX_PACKET_BYTES = 64;
   localparam int RANDOM_ITEMS     = 150;
   localparam int IDLE_PERCENT     = 14;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 16;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                push          = 1'b0;
   logic [CLIENT_W-1:0] req_client_id = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                pop           = 1'b0;
   logic                full;
   logic                empty;
   logic [CLIENT_W-1:0] rsp_source_client;
   logic [INDEX_W-1:0]  rsp_byte_index;
   logic [BYTE_W-1:0]   rsp_packet_byte;
   logic                rsp_last;
   logic                rsp_length_error;

   // Set while both sides run without gaps.
   logic                quiet         = 1'b0;
   // High for the cycle after a request has been accepted.
   logic                req_taken     = 1'b0;
   int                  mismatch_count;
   int                  outstanding;

   // Bytes still owed to each client's packet in progress.
   int                  bytes_left [NUM_CLIENTS];

   always #5 clock = ~clock;

   per_client_length_prefixed_deframer #(
      .NUM_CLIENTS      (NUM_CLIENTS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_client_id     (req_client_id),
      .req_data_byte     (req_data_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_source_client (rsp_source_client),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_packet_byte   (rsp_packet_byte),
      .rsp_last          (rsp_last),
      .rsp_length_error  (rsp_length_error)
   );

   packet_rebuild_monitor #(
      .NUM_CLIENTS      (NUM_CLIENTS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) monitor (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_client_id     (req_client_id),
      .req_data_byte     (req_data_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_source_client (rsp_source_client),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_packet_byte   (rsp_packet_byte),
      .rsp_last          (rsp_last),
      .rsp_length_error  (rsp_length_error),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   // Record request acceptance so that the driver can react at the falling edge.
   always @(posedge clock) begin
      req_taken <= push && !full;
   end

   // The response side stalls at random, except during the quiet stretch.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Presents one request, with random gaps ahead of it, and holds it until
   // it has been accepted.
   task automatic send_request(input logic [CLIENT_W-1:0] client,
                               input logic [BYTE_W-1:0] value);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         push = 1'b0;
         @(negedge clock);
      end
      push          = 1'b1;
      req_client_id = client;
      req_data_byte = value;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
   endtask

   // Ends the run if neither channel moves for too long.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (reset) @(negedge clock);
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [CLIENT_W-1:0] client;
      logic [BYTE_W-1:0]   value;
      int                  roll;
      int                  sent;
      bit                  max_done;
      bit                  busy;

      for (int c = 0; c < NUM_CLIENTS; c++) bytes_left[c] = 0;
      max_done = 1'b0;
      client   = '0;

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Bad length bytes: zero, just above the maximum and all ones.
      send_request(3'd0, 8'd0);
      send_request(3'd1, 8'(MAX_PACKET_BYTES + 1));
      send_request(3'd7, 8'hFF);
      // One-byte packet, then a two-byte packet ending in all ones.
      send_request(3'd2, 8'd1);
      send_request(3'd3, 8'd2);
      send_request(3'd3, 8'hFF);
      // Two clients interleaved; the shorter one completes first.
      send_request(3'd4, 8'd3);
      send_request(3'd5, 8'd2);
      send_request(3'd4, 8'h00);
      send_request(3'd5, 8'hA5);
      send_request(3'd4, 8'h5A);
      // A four-byte packet with single-bit and single-zero-bit patterns.
      send_request(3'd6, 8'd4);
      send_request(3'd6, 8'h80);
      send_request(3'd6, 8'h01);
      send_request(3'd6, 8'h7F);
      // A new packet on a client whose previous packet is still draining.
      send_request(3'd2, 8'd2);
      send_request(3'd2, 8'h55);
      send_request(3'd2, 8'd1);

      // Random packets until the budget is spent and every packet is closed.
      sent = 0;
      busy = 1'b0;
      while (sent < RANDOM_ITEMS || busy) begin
         quiet = (sent >= 60 && sent < 110);
         if (sent >= RANDOM_ITEMS) begin
            do client = CLIENT_W'($urandom_range(NUM_CLIENTS - 1));
            while (bytes_left[client] == 0);
         end else if ($urandom_range(99) >= 50) begin
            client = CLIENT_W'($urandom_range(NUM_CLIENTS - 1));
         end

         if (bytes_left[client] == 0) begin
            roll = $urandom_range(99);
            if (!max_done && sent >= 30) begin
               value    = 8'(MAX_PACKET_BYTES);
               max_done = 1'b1;
            end else if (roll < 8) begin
               value = ($urandom_range(1) == 0) ? 8'd0 :
                       8'($urandom_range(255, MAX_PACKET_BYTES + 1));
            end else if (roll < 12) begin
               value = 8'($urandom_range(MAX_PACKET_BYTES, 9));
            end else begin
               value = 8'($urandom_range(8, 1));
            end
            if (value != 0 && int'(value) <= MAX_PACKET_BYTES) begin
               bytes_left[client] = int'(value) - 1;
            end
         end else begin
            value = 8'($urandom());
            bytes_left[client]--;
         end

         send_request(client, value);
         sent++;
         busy = 1'b0;
         for (int c = 0; c < NUM_CLIENTS; c++) begin
            if (bytes_left[c] != 0) busy = 1'b1;
         end
      end
      quiet = 1'b0;
      push  = 1'b0;

      // Let every predicted response arrive, then watch for strays.
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lpd_pkg.sv
rtl/lpd_front.sv
rtl/lpd_cmdq.sv
rtl/lpd_back.sv
rtl/per_client_length_prefixed_deframer.sv
verif/packet_rebuild_monitor.sv
verif/testbench.sv
